### sv/fbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg
// shared types, codes and the crc-16/ccitt-false byte update for the framer
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int unsigned FBC_MAX_PAYLOAD = 247;
    localparam logic [8:0]  FBC_COUNT_RESET = 9'd256;
    localparam logic [15:0] FBC_CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] FBC_CRC_POLY    = 16'h1021;

    typedef enum logic {
        OP_HEADER  = 1'b0,
        OP_PAYLOAD = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_KIND   = 2'd2,
        ERR_TYPE   = 2'd3
    } t_err;

    typedef enum logic {
        CFG_KIND_COUNT = 1'b0,
        CFG_TYPE_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  version;
        logic [7:0]  pkg_kind;
        logic [7:0]  flag_bits;
        logic [7:0]  reserved_byte;
        logic [15:0] sequence_req;
        logic [7:0]  msg_type;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        t_err       error_code;
    } t_out_item;

    // msb-first crc update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ FBC_CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/fbc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_in_if
// input channel: header or payload beat with valid/ready handshake
// ----------------------------------------------------------------------------
interface fbc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  version;
    logic [7:0]  pkg_kind;
    logic [7:0]  flag_bits;
    logic [7:0]  reserved_byte;
    logic [15:0] sequence_req;
    logic [7:0]  msg_type;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;

    modport source (
        output valid, opcode, version, pkg_kind, flag_bits, reserved_byte,
               sequence_req, msg_type, payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, version, pkg_kind, flag_bits, reserved_byte,
               sequence_req, msg_type, payload_length, payload_byte,
        output ready
    );
endinterface

### sv/fbc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_out_if
// output channel: one frame byte per beat with valid/ready handshake
// ----------------------------------------------------------------------------
interface fbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] error_code;

    modport source (
        output valid, out_byte, frame_end, error_code,
        input  ready
    );
    modport sink (
        input  valid, out_byte, frame_end, error_code,
        output ready
    );
endinterface

### sv/frame_builder_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_builder_crc16
// byte framer: header fields, payload bytes and a crc-16/ccitt-false trailer
// ----------------------------------------------------------------------------
// One beat leaves the output register per cycle while the output is ready, and
// the input register takes a new beat as soon as the one it holds has put out
// its last byte. A header puts out seven bytes (nine with an empty payload, one
// error beat when it fails a check), a payload beat one byte, the last payload
// beat of a frame three bytes (its byte and the two crc bytes), and a payload
// beat with no open frame is dropped. The single byte lane of the output
// register sets the pace; the crc advances one byte per cycle beside it while the output is ready.
module frame_builder_crc16 #(
    parameter int unsigned MAX_PAYLOAD = fbc_pkg::FBC_MAX_PAYLOAD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    fbc_in_if.sink     i_in,
    fbc_out_if.source  o_out
);

    localparam logic [3:0] IDX_FIRST   = 4'd0;
    localparam logic [3:0] IDX_TYPE    = 4'd6;
    localparam logic [3:0] IDX_CRC_HI  = 4'd7;
    localparam logic [3:0] IDX_CRC_LO  = 4'd8;
    localparam logic [7:0] MAX_LEN     = 8'(MAX_PAYLOAD);

    logic                r_in_valid;
    fbc_pkg::t_in_item   r_in;
    logic [3:0]          r_idx,        n_idx;
    logic [15:0]         r_crc,        n_crc;
    logic [7:0]          r_bytes_left, n_bytes_left;
    logic                r_frame_open, n_frame_open;
    logic [8:0]          r_kind_count;
    logic [8:0]          r_type_count;
    logic                r_out_valid;
    fbc_pkg::t_out_item  r_out;

    logic                out_free;
    logic                item_done;
    logic                emit;
    fbc_pkg::t_out_item  emit_item;
    fbc_pkg::t_err       hdr_err;
    logic [7:0]          hdr_byte;
    logic [15:0]         crc_base;
    logic                in_ready;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || item_done;

    // header check, length first, then kind, then type
    always_comb begin
        if (r_in.payload_length > MAX_LEN) begin
            hdr_err = fbc_pkg::ERR_LENGTH;
        end else if ({1'b0, r_in.pkg_kind} >= r_kind_count) begin
            hdr_err = fbc_pkg::ERR_KIND;
        end else if ({1'b0, r_in.msg_type} >= r_type_count) begin
            hdr_err = fbc_pkg::ERR_TYPE;
        end else begin
            hdr_err = fbc_pkg::ERR_NONE;
        end
    end

    always_comb begin
        case (r_idx)
            4'd0:    hdr_byte = r_in.version;
            4'd1:    hdr_byte = r_in.pkg_kind;
            4'd2:    hdr_byte = r_in.flag_bits;
            4'd3:    hdr_byte = r_in.reserved_byte;
            4'd4:    hdr_byte = r_in.sequence_req[15:8];
            4'd5:    hdr_byte = r_in.sequence_req[7:0];
            default: hdr_byte = r_in.msg_type;
        endcase
    end

    assign crc_base = (r_idx == IDX_FIRST) ? fbc_pkg::FBC_CRC_INIT : r_crc;

    always_comb begin
        n_idx        = r_idx;
        n_crc        = r_crc;
        n_bytes_left = r_bytes_left;
        n_frame_open = r_frame_open;
        item_done    = 1'b0;
        emit         = 1'b0;
        emit_item    = '{out_byte: 8'd0, frame_end: 1'b0, error_code: fbc_pkg::ERR_NONE};
        if (r_in_valid) begin
            if (r_in.opcode == fbc_pkg::OP_PAYLOAD && !r_frame_open && r_idx == IDX_FIRST) begin
                // stray payload beat
                item_done = 1'b1;
            end else if (out_free) begin
                emit = 1'b1;
                case (r_idx)
                    IDX_CRC_HI: begin
                        emit_item.out_byte = r_crc[15:8];
                        n_idx              = r_idx + 4'd1;
                    end
                    IDX_CRC_LO: begin
                        emit_item.out_byte  = r_crc[7:0];
                        emit_item.frame_end = 1'b1;
                        n_frame_open        = 1'b0;
                        n_bytes_left        = 8'd0;
                        n_crc               = fbc_pkg::FBC_CRC_INIT;
                        item_done           = 1'b1;
                    end
                    default: begin
                        if (r_in.opcode == fbc_pkg::OP_PAYLOAD) begin
                            emit_item.out_byte = r_in.payload_byte;
                            n_crc              = fbc_pkg::crc_byte(r_crc, r_in.payload_byte);
                            n_bytes_left       = r_bytes_left - 8'd1;
                            if (n_bytes_left == 8'd0) begin
                                n_idx = IDX_CRC_HI;
                            end else begin
                                item_done = 1'b1;
                            end
                        end else if (r_idx == IDX_FIRST && hdr_err != fbc_pkg::ERR_NONE) begin
                            emit_item.frame_end  = 1'b1;
                            emit_item.error_code = hdr_err;
                            n_frame_open         = 1'b0;
                            n_bytes_left         = 8'd0;
                            n_crc                = fbc_pkg::FBC_CRC_INIT;
                            item_done            = 1'b1;
                        end else begin
                            emit_item.out_byte = hdr_byte;
                            n_crc              = fbc_pkg::crc_byte(crc_base, hdr_byte);
                            if (r_idx == IDX_FIRST) begin
                                n_frame_open = 1'b0;
                                n_bytes_left = 8'd0;
                            end
                            if (r_idx == IDX_TYPE) begin
                                if (r_in.payload_length == 8'd0) begin
                                    n_idx = IDX_CRC_HI;
                                end else begin
                                    n_frame_open = 1'b1;
                                    n_bytes_left = r_in.payload_length;
                                    item_done    = 1'b1;
                                end
                            end else begin
                                n_idx = r_idx + 4'd1;
                            end
                        end
                    end
                endcase
            end
        end
        if (item_done) begin
            n_idx = IDX_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_idx        <= IDX_FIRST;
            r_crc        <= fbc_pkg::FBC_CRC_INIT;
            r_bytes_left <= 8'd0;
            r_frame_open <= 1'b0;
            r_kind_count <= fbc_pkg::FBC_COUNT_RESET;
            r_type_count <= fbc_pkg::FBC_COUNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_idx        <= n_idx;
            r_crc        <= n_crc;
            r_bytes_left <= n_bytes_left;
            r_frame_open <= n_frame_open;
            if (i_in.valid && in_ready) begin
                r_in_valid <= 1'b1;
            end else if (item_done) begin
                r_in_valid <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (fbc_pkg::t_cfg_idx'(i_cfg_idx))
                    fbc_pkg::CFG_KIND_COUNT: r_kind_count <= i_cfg_data;
                    fbc_pkg::CFG_TYPE_COUNT: r_type_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // data registers without reset: input item and output item
    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in.opcode         <= fbc_pkg::t_opcode'(i_in.opcode);
            r_in.version        <= i_in.version;
            r_in.pkg_kind       <= i_in.pkg_kind;
            r_in.flag_bits      <= i_in.flag_bits;
            r_in.reserved_byte  <= i_in.reserved_byte;
            r_in.sequence_req   <= i_in.sequence_req;
            r_in.msg_type       <= i_in.msg_type;
            r_in.payload_length <= i_in.payload_length;
            r_in.payload_byte   <= i_in.payload_byte;
        end
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out.out_byte;
    assign o_out.frame_end  = r_out.frame_end;
    assign o_out.error_code = r_out.error_code;

    // error beats carry a zero byte and close the frame
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != fbc_pkg::ERR_NONE) |->
            (r_out.frame_end && r_out.out_byte == 8'd0))
        else $error("error beat with data or without frame end");

    // an open frame expects more payload until its crc bytes start
    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_open && r_idx < IDX_CRC_HI) |-> (r_bytes_left != 8'd0))
        else $error("frame open with no bytes left");

    // a beat in progress is never left without its input item
    a_idx_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != IDX_FIRST) |-> (r_in_valid && r_idx <= IDX_CRC_LO))
        else $error("byte index without an item");

endmodule
